[rtl/bfp_pkg.sv]
// shared types and constants for the bit field pack/unpack block
package bfp_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned INDEX_W  = 16;
  localparam int unsigned CURSOR_W = 16;
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned OFF_W    = 5;

  localparam logic [CFG_IDX_W-1:0] REG_WRITE_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_READ_LIMIT  = 1'b1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd32768;

  typedef enum logic [OP_W-1:0] {
    OP_WR_FIELD = 3'd0,
    OP_RD_FIELD = 3'd1,
    OP_WR_FLAG  = 3'd2,
    OP_RD_FLAG  = 3'd3,
    OP_SET_BIT  = 3'd4,
    OP_TEST_BIT = 3'd5,
    OP_SEEK     = 3'd6
  } op_e;

  typedef struct packed {
    logic                access;
    logic                wr;
    logic                rd_field;
    logic                rd_flag;
    logic                flag_w;
    logic                ok;
    logic                err;
    logic [CURSOR_W-1:0] cursor;
    logic [OFF_W-1:0]    off;
    logic [WORD_W-1:0]   mask;
    logic [WORD_W-1:0]   data;
    logic                sel_odd;
  } cmd_t;

endpackage

[rtl/bfp_if.sv]
// channel interfaces: input items, result items, register writes
interface bfp_in_if;
  logic                          valid;
  logic                          ready;
  logic [bfp_pkg::OP_W-1:0]      operation;
  logic [bfp_pkg::COUNT_W-1:0]   bit_count;
  logic [bfp_pkg::VALUE_W-1:0]   write_value;
  logic [bfp_pkg::INDEX_W-1:0]   bit_index;
  modport source (output valid, operation, bit_count, write_value, bit_index, input ready);
  modport sink   (input valid, operation, bit_count, write_value, bit_index, output ready);
endinterface

interface bfp_out_if;
  logic                          valid;
  logic                          ready;
  logic [bfp_pkg::VALUE_W-1:0]   read_value;
  logic                          flag_out;
  logic                          ok;
  logic [bfp_pkg::CURSOR_W-1:0]  cursor;
  logic                          error_seen;
  modport source (output valid, read_value, flag_out, ok, cursor, error_seen, input ready);
  modport sink   (input valid, read_value, flag_out, ok, cursor, error_seen, output ready);
endinterface

interface bfp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bfp_pkg::CFG_IDX_W-1:0] index;
  logic [bfp_pkg::LIMIT_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/bfp_ram.sv]
// generic simple dual-port ram with registered read
module bfp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[rtl/bfp_issue.sv]
// front stage: limit checks, cursor and error update, memory read issue
module bfp_issue #(
  parameter int unsigned BUF_BYTES      = 4096,
  parameter int unsigned MAX_FIELD_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  bfp_in_if.sink                 in_i,
  bfp_cfg_if.sink                cfg_i,
  input  logic                   take_ok_i,
  output logic                   accept_o,
  output bfp_pkg::cmd_t          cmd_o,
  output logic [(BUF_BYTES > 15 ? $clog2((BUF_BYTES + 7) / 8) : 1)-1:0] addr0_o,
  output logic [(BUF_BYTES > 15 ? $clog2((BUF_BYTES + 7) / 8) : 1)-1:0] addr1_o
);
  localparam int unsigned STORE_BITS = BUF_BYTES * 8;
  localparam int unsigned BANK_DEPTH = (BUF_BYTES + 7) / 8;
  localparam int unsigned AW = BANK_DEPTH > 1 ? $clog2(BANK_DEPTH) : 1;
  localparam int unsigned PW = AW + 6;
  localparam int unsigned CW = $clog2(STORE_BITS + 1);
  localparam int unsigned EW = (CW > 16 ? CW : 16) + 1;
  localparam int unsigned EMAX = MAX_FIELD_BITS < 32 ? MAX_FIELD_BITS : 32;

  logic [CW-1:0] cur_q, cur_d;
  logic          err_q, err_d;
  logic [bfp_pkg::LIMIT_W-1:0] wlim_q, rlim_q;

  logic [EW-1:0] store_e, wlim_e, rlim_e, cur_e, cnt_e, idx_e, sum_e, lim_e, pos_e, new_cur_e;
  logic [bfp_pkg::COUNT_W-1:0] n;
  logic [32:0]   mfull;
  logic [31:0]   m32;
  logic          acc, wr, rdf, rdfl, flag_w, ok, fail, use_idx;
  logic [PW-1:0] pos;
  bfp_pkg::op_e  op;

  assign op      = bfp_pkg::op_e'(in_i.operation);
  assign store_e = EW'(STORE_BITS);
  assign wlim_e  = ({1'b0, wlim_q} > store_e[16:0]) && (EW > 17 ? 1'b0 : 1'b1) ? store_e
                 : (EW'(wlim_q) > store_e ? store_e : EW'(wlim_q));
  assign rlim_e  = EW'(rlim_q) > store_e ? store_e : EW'(rlim_q);
  assign cur_e   = EW'(cur_q);
  assign cnt_e   = EW'(in_i.bit_count);
  assign idx_e   = EW'(in_i.bit_index);
  assign sum_e   = cur_e + cnt_e;
  assign lim_e   = (op == bfp_pkg::OP_WR_FIELD) ? wlim_e : rlim_e;

  always_comb begin
    acc     = 1'b0;
    wr      = 1'b0;
    rdf     = 1'b0;
    rdfl    = 1'b0;
    flag_w  = 1'b0;
    ok      = 1'b0;
    fail    = 1'b0;
    use_idx = 1'b0;
    n       = bfp_pkg::COUNT_W'(1);
    new_cur_e = cur_e;
    unique case (op)
      bfp_pkg::OP_WR_FIELD, bfp_pkg::OP_RD_FIELD: begin
        n = in_i.bit_count;
        if (in_i.bit_count > bfp_pkg::COUNT_W'(EMAX)) begin
          fail = 1'b1;
        end else if (in_i.bit_count == '0) begin
          ok = 1'b1;
        end else if (sum_e > lim_e) begin
          fail = 1'b1;
        end else begin
          acc = 1'b1;
          ok  = 1'b1;
          wr  = (op == bfp_pkg::OP_WR_FIELD);
          rdf = (op == bfp_pkg::OP_RD_FIELD);
          new_cur_e = sum_e;
        end
      end
      bfp_pkg::OP_WR_FLAG: begin
        if (cur_e + EW'(1) > wlim_e) begin
          fail = 1'b1;
        end else begin
          acc = 1'b1;
          wr  = 1'b1;
          ok  = 1'b1;
          flag_w = in_i.write_value[0];
          new_cur_e = cur_e + EW'(1);
        end
      end
      bfp_pkg::OP_RD_FLAG: begin
        if (cur_e >= rlim_e) begin
          fail = 1'b1;
        end else begin
          acc  = 1'b1;
          rdfl = 1'b1;
          ok   = 1'b1;
          new_cur_e = cur_e + EW'(1);
        end
      end
      bfp_pkg::OP_SET_BIT: begin
        use_idx = 1'b1;
        if (idx_e >= wlim_e) begin
          fail = 1'b1;
        end else begin
          acc = 1'b1;
          wr  = 1'b1;
          ok  = 1'b1;
        end
      end
      bfp_pkg::OP_TEST_BIT: begin
        use_idx = 1'b1;
        if (idx_e >= rlim_e) begin
          fail = 1'b1;
        end else begin
          acc  = 1'b1;
          rdfl = 1'b1;
          ok   = 1'b1;
        end
      end
      bfp_pkg::OP_SEEK: begin
        if (idx_e > store_e) begin
          fail = 1'b1;
        end else begin
          ok = 1'b1;
          new_cur_e = idx_e;
        end
      end
      default: begin
      end
    endcase
  end

  assign pos_e = use_idx ? idx_e : cur_e;
  assign pos   = pos_e[PW-1:0];
  assign mfull = (33'd1 << n) - 33'd1;
  assign m32   = mfull[31:0];

  assign accept_o = in_i.valid && take_ok_i;
  assign in_i.ready = take_ok_i;
  assign cfg_i.ready = 1'b1;

  assign cur_d = accept_o ? new_cur_e[CW-1:0] : cur_q;
  assign err_d = err_q || (accept_o && fail);

  always_comb begin
    cmd_o          = '0;
    cmd_o.access   = acc;
    cmd_o.wr       = wr;
    cmd_o.rd_field = rdf;
    cmd_o.rd_flag  = rdfl;
    cmd_o.flag_w   = flag_w;
    cmd_o.ok       = ok;
    cmd_o.err      = err_q || fail;
    cmd_o.cursor   = new_cur_e[bfp_pkg::CURSOR_W-1:0];
    cmd_o.off      = pos[4:0];
    cmd_o.mask     = m32;
    cmd_o.data     = (op == bfp_pkg::OP_WR_FIELD) ? (in_i.write_value & m32)
                                                  : {31'b0, in_i.write_value[0]};
    cmd_o.sel_odd  = pos[5];
  end

  assign addr1_o = pos[PW-1:6];
  assign addr0_o = pos[PW-1:6] + AW'(pos[5]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      err_q  <= 1'b0;
      wlim_q <= bfp_pkg::LIMIT_RESET;
      rlim_q <= bfp_pkg::LIMIT_RESET;
    end else begin
      cur_q <= cur_d;
      err_q <= err_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          bfp_pkg::REG_WRITE_LIMIT: wlim_q <= cfg_i.data;
          bfp_pkg::REG_READ_LIMIT:  rlim_q <= cfg_i.data;
          default: begin
          end
        endcase
      end
    end
  end
endmodule

[rtl/bfp_rmw.sv]
// back stage: forwarding merge, write-back, result register and clearing pass
module bfp_rmw #(
  parameter int unsigned BUF_BYTES = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  bfp_pkg::cmd_t          cmd_i,
  input  logic [(BUF_BYTES > 15 ? $clog2((BUF_BYTES + 7) / 8) : 1)-1:0] addr0_i,
  input  logic [(BUF_BYTES > 15 ? $clog2((BUF_BYTES + 7) / 8) : 1)-1:0] addr1_i,
  input  logic [bfp_pkg::WORD_W-1:0] rdata0_i,
  input  logic [bfp_pkg::WORD_W-1:0] rdata1_i,
  output logic                   we0_o,
  output logic [(BUF_BYTES > 15 ? $clog2((BUF_BYTES + 7) / 8) : 1)-1:0] wa0_o,
  output logic [bfp_pkg::WORD_W-1:0] wd0_o,
  output logic                   we1_o,
  output logic [(BUF_BYTES > 15 ? $clog2((BUF_BYTES + 7) / 8) : 1)-1:0] wa1_o,
  output logic [bfp_pkg::WORD_W-1:0] wd1_o,
  output logic                   take_ok_o,
  bfp_out_if.source              out_o
);
  localparam int unsigned BANK_DEPTH = (BUF_BYTES + 7) / 8;
  localparam int unsigned AW = BANK_DEPTH > 1 ? $clog2(BANK_DEPTH) : 1;

  logic          s1_valid_q;
  bfp_pkg::cmd_t cmd_q;
  logic [AW-1:0] a0_q, a1_q;
  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;
  logic          f0_valid_q, f1_valid_q;
  logic [AW-1:0] f0_addr_q, f1_addr_q;
  logic [31:0]   f0_data_q, f1_data_q;
  logic          out_valid_q;
  logic [31:0]   rv_q;
  logic          flag_q, ok_q, err_q;
  logic [bfp_pkg::CURSOR_W-1:0] cur_q;

  logic          fire;
  logic [31:0]   d0, d1, lo_w, hi_w, nlo, nhi, rv;
  logic [63:0]   win, m64, dat64, nwin, rv64;
  logic          w0, w1;

  assign fire      = s1_valid_q && (!out_valid_q || out_o.ready);
  assign take_ok_o = !clr_q && (!s1_valid_q || fire);

  assign d0 = (f0_valid_q && f0_addr_q == a0_q) ? f0_data_q : rdata0_i;
  assign d1 = (f1_valid_q && f1_addr_q == a1_q) ? f1_data_q : rdata1_i;

  assign lo_w  = cmd_q.sel_odd ? d1 : d0;
  assign hi_w  = cmd_q.sel_odd ? d0 : d1;
  assign win   = {hi_w, lo_w};
  assign m64   = {32'b0, cmd_q.mask} << cmd_q.off;
  assign dat64 = {32'b0, cmd_q.data} << cmd_q.off;
  assign nwin  = (win & ~m64) | dat64;
  assign nlo   = nwin[31:0];
  assign nhi   = nwin[63:32];
  assign rv64  = win >> cmd_q.off;
  assign rv    = rv64[31:0] & cmd_q.mask;

  assign w0 = fire && cmd_q.access && cmd_q.wr && (!cmd_q.sel_odd || (m64[63:32] != '0));
  assign w1 = fire && cmd_q.access && cmd_q.wr && (cmd_q.sel_odd || (m64[63:32] != '0));

  assign we0_o = clr_q || w0;
  assign we1_o = clr_q || w1;
  assign wa0_o = clr_q ? clr_cnt_q : a0_q;
  assign wa1_o = clr_q ? clr_cnt_q : a1_q;
  assign wd0_o = clr_q ? '0 : (cmd_q.sel_odd ? nhi : nlo);
  assign wd1_o = clr_q ? '0 : (cmd_q.sel_odd ? nlo : nhi);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      f0_valid_q  <= 1'b0;
      f1_valid_q  <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(BANK_DEPTH - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (accept_i) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (w0) begin
        f0_valid_q <= 1'b1;
      end
      if (w1) begin
        f1_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      cmd_q <= cmd_i;
      a0_q  <= addr0_i;
      a1_q  <= addr1_i;
    end
    if (w0) begin
      f0_addr_q <= a0_q;
      f0_data_q <= wd0_o;
    end
    if (w1) begin
      f1_addr_q <= a1_q;
      f1_data_q <= wd1_o;
    end
    if (fire) begin
      rv_q   <= cmd_q.rd_field ? rv : '0;
      flag_q <= cmd_q.rd_flag ? rv[0] : cmd_q.flag_w;
      ok_q   <= cmd_q.ok;
      err_q  <= cmd_q.err;
      cur_q  <= cmd_q.cursor;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = rv_q;
  assign out_o.flag_out   = flag_q;
  assign out_o.ok         = ok_q;
  assign out_o.cursor     = cur_q;
  assign out_o.error_seen = err_q;

  a_no_take_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !take_ok_o) else $error("transaction taken during clearing pass");
  a_fire_fills_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q) else $error("result register not loaded");
  a_clear_before_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s1_valid_q) else $error("work in flight during clearing pass");
  a_write_needs_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (w0 || w1) |-> (s1_valid_q && cmd_q.wr && cmd_q.ok)) else $error("stray store write");
endmodule

[rtl/bit_field_pack_unpack_top.sv]
// top level of the lsb-first bit field pack/unpack block
// usage:
//   in_i carries one operation per transaction (write/read field, write/read flag,
//   set/test bit, seek); out_o returns exactly one result per operation, in order.
//   cfg_i writes the write limit (index 0) and read limit (index 1); it is always ready
//   and must only be used while no operation is in flight.
// datapath:
//   a taken operation waits in the second stage until the result register can take it;
//   one operation per cycle is sustained while out_o is ready. the store is two 32-bit
//   word banks read at the taking edge and written back when the result is registered,
//   with a one-entry forward per bank for back-to-back accesses to the same word.
// reset:
//   cursor, sticky error and limits reset at once; the store is then zeroed by a clearing
//   pass of each bank's (BUF_BYTES+7)/8 words (512 by default), with in_i not ready.
// stalls:
//   while out_o is held, one further operation waits in the second stage; after that
//   in_i drops ready until the result register drains.
module bit_field_pack_unpack_top #(
  parameter int unsigned BUF_BYTES      = 4096,
  parameter int unsigned MAX_FIELD_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bfp_in_if.sink    in_i,
  bfp_cfg_if.sink   cfg_i,
  bfp_out_if.source out_o
);
  localparam int unsigned BANK_DEPTH = (BUF_BYTES + 7) / 8;
  localparam int unsigned AW = BANK_DEPTH > 1 ? $clog2(BANK_DEPTH) : 1;

  logic          accept, take_ok;
  bfp_pkg::cmd_t cmd;
  logic [AW-1:0] ra0, ra1, wa0, wa1;
  logic [31:0]   rd0, rd1, wd0, wd1;
  logic          we0, we1;

  bfp_issue #(.BUF_BYTES(BUF_BYTES), .MAX_FIELD_BITS(MAX_FIELD_BITS)) u_issue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_i     (cfg_i),
    .take_ok_i (take_ok),
    .accept_o  (accept),
    .cmd_o     (cmd),
    .addr0_o   (ra0),
    .addr1_o   (ra1)
  );

  bfp_ram #(.WIDTH(bfp_pkg::WORD_W), .DEPTH(BANK_DEPTH)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (wa0),
    .wdata_i (wd0),
    .re_i    (accept),
    .raddr_i (ra0),
    .rdata_o (rd0)
  );

  bfp_ram #(.WIDTH(bfp_pkg::WORD_W), .DEPTH(BANK_DEPTH)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (wa1),
    .wdata_i (wd1),
    .re_i    (accept),
    .raddr_i (ra1),
    .rdata_o (rd1)
  );

  bfp_rmw #(.BUF_BYTES(BUF_BYTES)) u_rmw (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .cmd_i     (cmd),
    .addr0_i   (ra0),
    .addr1_i   (ra1),
    .rdata0_i  (rd0),
    .rdata1_i  (rd1),
    .we0_o     (we0),
    .wa0_o     (wa0),
    .wd0_o     (wd0),
    .we1_o     (we1),
    .wa1_o     (wa1),
    .wd1_o     (wd1),
    .take_ok_o (take_ok),
    .out_o     (out_o)
  );
endmodule

[tb/bfp_checker.sv]
// checker: watches the channels, predicts each result and compares
`timescale 1ns / 100ps
module bfp_checker #(
  parameter int unsigned BUF_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bfp_in_if.sink      in_mon,
  bfp_cfg_if.sink     cfg_mon,
  bfp_out_if.sink     out_mon,
  output int unsigned fail_count,
  output int unsigned pending_count,
  output int unsigned result_count,
  output int unsigned ok_count,
  output int unsigned err_count
);

  localparam int unsigned STORE_BITS = BUF_BYTES * 8;

  typedef struct packed {
    logic [bfp_pkg::VALUE_W-1:0]  read_value;
    logic                         flag_out;
    logic                         ok;
    logic [bfp_pkg::CURSOR_W-1:0] cursor;
    logic                         error_seen;
  } result_t;

  logic [7:0]                  shadow_bytes [BUF_BYTES];
  int unsigned                 shadow_cursor;
  logic                        shadow_error;
  logic [bfp_pkg::LIMIT_W-1:0] wr_limit_reg;
  logic [bfp_pkg::LIMIT_W-1:0] rd_limit_reg;
  result_t                     expected_q [$];

  function automatic logic store_bit(int unsigned idx);
    if (idx >= STORE_BITS) return 1'b0;
    return shadow_bytes[idx >> 3][idx & 7];
  endfunction

  task automatic put_store_bit(int unsigned idx, logic v);
    if (idx < STORE_BITS) shadow_bytes[idx >> 3][idx & 7] = v;
  endtask

  task automatic pack_unpack_step(logic [bfp_pkg::OP_W-1:0] op,
                                  logic [bfp_pkg::COUNT_W-1:0] cnt,
                                  logic [bfp_pkg::VALUE_W-1:0] val,
                                  logic [bfp_pkg::INDEX_W-1:0] idx);
    int unsigned wlim;
    int unsigned rlim;
    logic        failed;
    result_t     r;
    wlim   = (wr_limit_reg > STORE_BITS) ? STORE_BITS : wr_limit_reg;
    rlim   = (rd_limit_reg > STORE_BITS) ? STORE_BITS : rd_limit_reg;
    failed = 1'b0;
    r      = '0;
    case (op)
      bfp_pkg::OP_WR_FIELD, bfp_pkg::OP_RD_FIELD: begin
        if (cnt > 32) failed = 1'b1;
        else if (cnt == 0) r.ok = 1'b1;
        else if (shadow_cursor + cnt > ((op == bfp_pkg::OP_WR_FIELD) ? wlim : rlim))
          failed = 1'b1;
        else begin
          for (int i = 0; i < cnt; i++) begin
            if (op == bfp_pkg::OP_WR_FIELD) put_store_bit(shadow_cursor + i, val[i]);
            else r.read_value[i] = store_bit(shadow_cursor + i);
          end
          shadow_cursor += cnt;
          r.ok = 1'b1;
        end
      end
      bfp_pkg::OP_WR_FLAG: begin
        if (shadow_cursor + 1 > wlim) failed = 1'b1;
        else begin
          put_store_bit(shadow_cursor, val[0]);
          r.flag_out = val[0];
          shadow_cursor++;
          r.ok = 1'b1;
        end
      end
      bfp_pkg::OP_RD_FLAG: begin
        if (shadow_cursor >= rlim) failed = 1'b1;
        else begin
          r.flag_out = store_bit(shadow_cursor);
          shadow_cursor++;
          r.ok = 1'b1;
        end
      end
      bfp_pkg::OP_SET_BIT: begin
        if (idx >= wlim) failed = 1'b1;
        else begin
          put_store_bit(idx, val[0]);
          r.ok = 1'b1;
        end
      end
      bfp_pkg::OP_TEST_BIT: begin
        if (idx >= rlim) failed = 1'b1;
        else begin
          r.flag_out = store_bit(idx);
          r.ok = 1'b1;
        end
      end
      bfp_pkg::OP_SEEK: begin
        if (idx > STORE_BITS) failed = 1'b1;
        else begin
          shadow_cursor = idx;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    if (failed) shadow_error = 1'b1;
    r.cursor     = shadow_cursor[bfp_pkg::CURSOR_W-1:0];
    r.error_seen = shadow_error;
    expected_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    result_t got_r;
    if (!rst_ni) begin
      foreach (shadow_bytes[i]) shadow_bytes[i] = 8'h00;
      shadow_cursor = 0;
      shadow_error  = 1'b0;
      wr_limit_reg  = bfp_pkg::LIMIT_RESET;
      rd_limit_reg  = bfp_pkg::LIMIT_RESET;
      expected_q.delete();
      fail_count    <= 0;
      pending_count <= 0;
      result_count  <= 0;
      ok_count      <= 0;
      err_count     <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == bfp_pkg::REG_WRITE_LIMIT) wr_limit_reg = cfg_mon.data;
        else rd_limit_reg = cfg_mon.data;
      end
      if (out_mon.valid && out_mon.ready) begin
        got_r = '{out_mon.read_value, out_mon.flag_out, out_mon.ok, out_mon.cursor,
                  out_mon.error_seen};
        result_count <= result_count + 1;
        if (got_r.ok) ok_count <= ok_count + 1;
        else err_count <= err_count + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got_r);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got_r !== exp_r) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_r, got_r);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        pack_unpack_step(in_mon.operation, in_mon.bit_count, in_mon.write_value,
                         in_mon.bit_index);
      pending_count <= $unsigned(expected_q.size());
    end
  end

endmodule

[tb/bit_field_pack_unpack_top_tb.sv]
// testbench top: stimulus, register phases, receiver stalls and verdict
`timescale 1ns / 100ps
module bit_field_pack_unpack_top_tb;

  localparam int unsigned WATCHDOG_LIMIT = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bfp_in_if  in_ch ();
  bfp_out_if out_ch ();
  bfp_cfg_if cfg_ch ();

  int unsigned fail_count, pending_count, result_count, ok_count, err_count;
  int unsigned idle_cycles;
  logic        hold_off;
  logic        timed_out;

  bit_field_pack_unpack_top dut (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_i (in_ch), .cfg_i (cfg_ch), .out_o (out_ch)
  );

  bfp_checker u_checker (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_mon (in_ch), .cfg_mon (cfg_ch),
    .out_mon (out_ch), .fail_count (fail_count), .pending_count (pending_count),
    .result_count (result_count), .ok_count (ok_count), .err_count (err_count)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.operation = '0; in_ch.bit_count = '0;
    in_ch.write_value = '0; in_ch.bit_index = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    hold_off = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk_i) begin
    int unsigned mode;
    mode = 32'(($time / 20000) % 3);
    if (hold_off) out_ch.ready <= 1'b0;
    else if (mode == 0) out_ch.ready <= 1'b1;
    else if (mode == 1) out_ch.ready <= ($urandom_range(0, 3) != 0);
    else out_ch.ready <= ($urandom_range(0, 2) == 0);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idle_cycles <= 0;
    else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
             || (cfg_ch.valid && cfg_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  assign timed_out = idle_cycles >= WATCHDOG_LIMIT;

  always @(posedge clk_i) begin
    if (timed_out) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_op(bfp_pkg::op_e op, int unsigned cnt, logic [31:0] val,
                         int unsigned idx);
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.bit_count   <= cnt[bfp_pkg::COUNT_W-1:0];
    in_ch.write_value <= val;
    in_ch.bit_index   <= idx[bfp_pkg::INDEX_W-1:0];
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic send_raw(logic [bfp_pkg::OP_W-1:0] op, int unsigned cnt, logic [31:0] val,
                          int unsigned idx);
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.bit_count   <= cnt[bfp_pkg::COUNT_W-1:0];
    in_ch.write_value <= val;
    in_ch.bit_index   <= idx[bfp_pkg::INDEX_W-1:0];
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic pause_sender();
    in_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limits(int unsigned wlim, int unsigned rlim);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= bfp_pkg::REG_WRITE_LIMIT;
    cfg_ch.data  <= wlim[bfp_pkg::LIMIT_W-1:0];
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.index <= bfp_pkg::REG_READ_LIMIT;
    cfg_ch.data  <= rlim[bfp_pkg::LIMIT_W-1:0];
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_op(int unsigned region);
    int unsigned pick;
    int unsigned idx;
    pick = $urandom_range(0, 99);
    idx  = (pick < 95) ? $urandom_range(0, region) : $urandom_range(0, 65535);
    if (pick < 25)      send_op(bfp_pkg::OP_WR_FIELD, $urandom_range(0, 32), $urandom(), 0);
    else if (pick < 48) send_op(bfp_pkg::OP_RD_FIELD, $urandom_range(0, 32), $urandom(), 0);
    else if (pick < 56) send_op(bfp_pkg::OP_WR_FLAG, 0, $urandom(), 0);
    else if (pick < 64) send_op(bfp_pkg::OP_RD_FLAG, 0, $urandom(), 0);
    else if (pick < 72) send_op(bfp_pkg::OP_SET_BIT, 0, $urandom(), idx);
    else if (pick < 80) send_op(bfp_pkg::OP_TEST_BIT, 0, $urandom(), idx);
    else if (pick < 92) send_op(bfp_pkg::OP_SEEK, 0, $urandom(), idx);
    else if (pick < 96)
      send_raw(3'($urandom_range(0, 7)), $urandom_range(33, 63), $urandom(), $urandom());
    else send_raw(3'd7, $urandom_range(0, 63), $urandom(), $urandom());
  endtask

  task automatic random_phase(int unsigned n_items, int unsigned region);
    int unsigned burst;
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        if (sent < n_items) random_op(region);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender();
    end
    drain();
  endtask

  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    // directed: field extremes, every operation, the special cases
    send_op(bfp_pkg::OP_WR_FIELD, 32, 32'hFFFF_FFFF, 0);
    send_op(bfp_pkg::OP_WR_FIELD, 0, 32'h1234_5678, 0);
    send_op(bfp_pkg::OP_WR_FIELD, 1, 32'h0000_0001, 0);
    send_op(bfp_pkg::OP_WR_FLAG, 0, 32'h0000_0001, 0);
    send_op(bfp_pkg::OP_WR_FLAG, 0, 32'hFFFF_FFFE, 0);
    send_op(bfp_pkg::OP_SEEK, 0, 0, 0);
    send_op(bfp_pkg::OP_RD_FIELD, 32, 0, 0);
    send_op(bfp_pkg::OP_RD_FIELD, 0, 0, 0);
    send_op(bfp_pkg::OP_RD_FLAG, 0, 0, 0);
    send_op(bfp_pkg::OP_RD_FLAG, 0, 0, 0);
    send_op(bfp_pkg::OP_SET_BIT, 0, 1, 32767);
    send_op(bfp_pkg::OP_TEST_BIT, 0, 0, 32767);
    send_op(bfp_pkg::OP_SET_BIT, 0, 1, 32768);
    send_op(bfp_pkg::OP_TEST_BIT, 0, 0, 65535);
    send_op(bfp_pkg::OP_SEEK, 0, 0, 32768);
    send_op(bfp_pkg::OP_RD_FLAG, 0, 0, 0);
    send_op(bfp_pkg::OP_WR_FIELD, 1, 1, 0);
    send_op(bfp_pkg::OP_SEEK, 0, 0, 32769);
    send_op(bfp_pkg::OP_SEEK, 0, 0, 32760);
    send_op(bfp_pkg::OP_RD_FIELD, 8, 0, 0);
    send_op(bfp_pkg::OP_WR_FIELD, 33, 32'hA5A5_A5A5, 0);
    send_raw(3'd7, 63, 32'hFFFF_FFFF, 16'hFFFF);
    send_op(bfp_pkg::OP_SEEK, 0, 0, 32735);
    send_op(bfp_pkg::OP_WR_FIELD, 32, 32'hDEAD_BEEF, 0);
    send_op(bfp_pkg::OP_RD_FIELD, 32, 0, 0);
    drain();

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_op(bfp_pkg::OP_SEEK, 0, 0, 0);
        repeat (60) random_op(256);
      end
    join
    drain();

    random_phase(300, 512);
    write_limits(0, 0);
    random_phase(60, 64);
    write_limits(65535, 65535);
    random_phase(220, 32768);
    write_limits($urandom_range(20, 200), $urandom_range(20, 200));
    random_phase(250, 256);
    write_limits(32768, 17);
    random_phase(150, 128);
    write_limits(40, 32768);
    random_phase(200, 128);

    $display("run covered %0d results: %0d succeeded, %0d failed on bounds or codes",
             result_count, ok_count, err_count);
    $display("limits swept from zero to full scale, with receiver stalls and a long hold-off");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
